FILE: sv/actr_pkg.sv
// Shared types, constants and AES helper functions for the AES counter-mode cipher.
// Depends on nothing; the core, the top and the bench use it by scoped names.
package actr_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned RkWords = 60;   // 32-bit round-key words, 15 round keys
  localparam int unsigned RkIdxW = 6;

  localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEYLEN = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_IVHI = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_IVLO = 3'd6;

  localparam logic [1:0] KEYLEN_128 = 2'd0;
  localparam logic [1:0] KEYLEN_192 = 2'd1;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] POLY_BITS = 8'h1B;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYEXP,
    ST_INIT,
    ST_ROUND,
    ST_XOR,
    ST_OUT
  } state_t;

  // Request from the top to the AES core and its status
  typedef struct packed {
    logic expand;
    logic encrypt;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] s [256];
    s = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return s[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? POLY_BITS : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // One column through MixColumns; byte 0 is the most significant
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, al;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    al = a0 ^ a1 ^ a2 ^ a3;
    return {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
            a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
  endfunction

endpackage

FILE: sv/actr_stream_if.sv
// Valid/ready channel carrying one byte item and its end-of-chunk flag.
// Depends on nothing.
interface actr_stream_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       last;

  modport source (output valid, data, last, input ready);
  modport sink (input valid, data, last, output ready);
endinterface

FILE: sv/actr_core.sv
// Iterative AES unit: key expansion one word a cycle, rounds one at a time.
// Depends on actr_pkg for the S-box, helpers and control structs.
module actr_core (
  input  logic                       clk,
  input  logic                       rst,
  input  actr_pkg::core_req_t        req,
  input  logic [255:0]               key,
  input  logic [1:0]                 key_length,
  input  logic [127:0]               block_in,
  output logic [127:0]               block_out,
  output actr_pkg::core_sts_t        sts
);

  actr_pkg::state_t state, state_next;

  // Round-key memory: one round key an entry, written one word per cycle
  logic [127:0] rk_mem [actr_pkg::RkWords/4];
  logic [actr_pkg::RkIdxW-1:0] widx;
  logic [3:0] nk;
  logic [3:0] ki;        // widx mod nk
  logic [3:0] nr;
  logic [3:0] round;
  logic [3:0] rk_addr;
  logic [7:0] rcon;
  logic [255:0] win;     // last nk words, newest at the low end
  logic [127:0] st;
  logic [actr_pkg::RkIdxW-1:0] total;

  logic [31:0] prev_w, old_w, tmp_w, new_w;
  logic [127:0] sub_st, shift_st, mix_st, rk_blk;

  always_comb begin
    case (key_length)
      actr_pkg::KEYLEN_128: begin
        nk = 4'd4;
        nr = 4'd10;
      end
      actr_pkg::KEYLEN_192: begin
        nk = 4'd6;
        nr = 4'd12;
      end
      default: begin
        nk = 4'd8;
        nr = 4'd14;
      end
    endcase
    total = 6'(4 * ({2'b0, nr} + 6'd1));
  end

  // Key schedule step
  always_comb begin
    prev_w = win[31:0];
    old_w  = win[32*nk-1 -: 32];
    tmp_w  = prev_w;
    if (ki == 4'd0) begin
      tmp_w = actr_pkg::sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && ki == 4'd4) begin
      tmp_w = actr_pkg::sub_word(prev_w);
    end
    new_w = old_w ^ tmp_w;
  end

  // Round datapath; byte i of the state sits at st[127-8*i -: 8]
  always_comb begin
    sub_st = '0;
    shift_st = '0;
    mix_st = '0;
    for (int i = 0; i < 16; i++) begin
      sub_st[127-8*i -: 8] = actr_pkg::sbox(st[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shift_st[127-8*(r+4*c) -: 8] = sub_st[127-8*(r+4*((c+r)%4)) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mix_st[127-32*c -: 32] = actr_pkg::mix_col(shift_st[127-32*c -: 32]);
    end
  end

  // Fetch the key of the coming round while the wait cycle runs
  assign rk_addr = (state == actr_pkg::ST_XOR) ? round + 4'd1 : round;

  always_ff @(posedge clk) begin
    rk_blk <= rk_mem[rk_addr];
  end

  always_ff @(posedge clk) begin
    if (state == actr_pkg::ST_KEYEXP) begin
      rk_mem[widx[actr_pkg::RkIdxW-1:2]][127 - 32*widx[1:0] -: 32] <=
        (widx < actr_pkg::RkIdxW'(nk)) ? win[255 - 32*widx -: 32] : new_w;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      actr_pkg::ST_IDLE: begin
        if (req.expand) state_next = actr_pkg::ST_KEYEXP;
        else if (req.encrypt) state_next = actr_pkg::ST_INIT;
      end
      actr_pkg::ST_KEYEXP: begin
        if (widx == total - 6'd1) state_next = actr_pkg::ST_IDLE;
      end
      actr_pkg::ST_INIT: state_next = actr_pkg::ST_XOR;
      actr_pkg::ST_XOR: state_next = actr_pkg::ST_ROUND;
      actr_pkg::ST_ROUND: begin
        if (round == nr) state_next = actr_pkg::ST_OUT;
        else state_next = actr_pkg::ST_XOR;
      end
      actr_pkg::ST_OUT: state_next = actr_pkg::ST_IDLE;
      default: state_next = actr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= actr_pkg::ST_KEYEXP;
      widx <= '0;
      ki <= '0;
      rcon <= actr_pkg::RCON_INIT;
      win <= '0;
      round <= '0;
    end else begin
      state <= state_next;
      case (state)
        actr_pkg::ST_IDLE: begin
          widx <= '0;
          ki <= '0;
          rcon <= actr_pkg::RCON_INIT;
          win <= key;
          round <= '0;
        end
        actr_pkg::ST_KEYEXP: begin
          widx <= widx + 6'd1;
          ki <= (ki == nk - 4'd1) ? 4'd0 : ki + 4'd1;
          if (widx >= actr_pkg::RkIdxW'(nk)) begin
            win <= {win[223:0], new_w};
            if (ki == 4'd0) rcon <= actr_pkg::xtime(rcon);
          end else if (widx == actr_pkg::RkIdxW'(nk) - 6'd1) begin
            // align the window so the newest key word is at the low end
            win <= win >> (256 - 32 * nk);
          end
        end
        actr_pkg::ST_INIT: begin
          st <= block_in;
        end
        actr_pkg::ST_XOR: begin
          // round key for this round is now in rk_blk
          if (round == 4'd0) st <= st ^ rk_blk;
          round <= round + 4'd1;
        end
        actr_pkg::ST_ROUND: begin
          if (round == nr) st <= shift_st ^ rk_blk;
          else st <= mix_st ^ rk_blk;
        end
        default: ;
      endcase
    end
  end

  assign block_out = st;
  assign sts.busy = (state != actr_pkg::ST_IDLE);
  assign sts.done = (state == actr_pkg::ST_OUT);

`ifndef NO_ASSERTIONS
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == actr_pkg::ST_ROUND |-> round != 4'd0 && round <= nr)
    else $error("round count out of range");
  a_done_after_round: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> $past(state) == actr_pkg::ST_ROUND)
    else $error("done without final round");
  a_widx_range: assert property (@(posedge clk) disable iff (rst)
    state == actr_pkg::ST_KEYEXP |-> widx < total)
    else $error("key schedule index overrun");
`endif

endmodule

FILE: sv/aes_ctr_stream_cipher.sv
// Top level of the byte-serial AES counter-mode cipher: registers, counter, key stream.
// Depends on actr_pkg, actr_stream_if and actr_core.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    data (data_in), last (end_of_chunk)
//  out_ch   out  valid/ready    data (data_out), last (last_out)
//  cfg      in   cfg_we         cfg_index, cfg_data
//
// A byte at offset 1..15 is accepted into the pending register, then moved to the output register.
// A byte at offset 0 runs the AES unit first: init, then a key-fetch and a round state per round, then output.
// A key or key-length write re-expands the round keys one word a cycle.
// Reset is synchronous; the key expansion of the all-zero key runs after it.
// in_ch.ready stays low while a byte is pending, a key change awaits expansion or the AES
// unit is busy; a result waiting in the output register holds back only the pending byte.
module aes_ctr_stream_cipher (
  input  logic                           clk,
  input  logic                           rst,
  actr_stream_if.sink                    in_ch,
  actr_stream_if.source                  out_ch,
  input  logic                           cfg_we,
  input  logic [actr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [actr_pkg::CfgDataW-1:0]  cfg_data
);

  logic [255:0] key;
  logic [1:0] key_length;
  logic [63:0] iv_high, iv_low, counter_high, counter_low;
  logic [3:0] byte_offset;
  logic [127:0] ks_reg, ks_blk;
  logic key_dirty;
  logic ks_fresh;        // key stream just computed for the block at offset zero
  logic pend;            // byte waiting for its key stream
  logic [7:0] pend_data;
  logic pend_last;
  logic out_valid;
  logic [7:0] out_data;
  logic out_last;
  logic [7:0] ks_byte;
  logic accept;
  logic deliver;
  logic key_wr;
  logic iv_wr;

  actr_pkg::core_req_t req;
  actr_pkg::core_sts_t sts;

  actr_core u_core (
    .clk(clk), .rst(rst), .req(req), .key(key), .key_length(key_length),
    .block_in({counter_high, counter_low}), .block_out(ks_blk), .sts(sts)
  );

  assign in_ch.ready = !pend && !sts.busy && !key_dirty;
  assign accept = in_ch.valid && in_ch.ready;

  // Start key expansion on a key change, encryption for a fresh block
  assign req.expand = key_dirty && !sts.busy;
  assign req.encrypt = pend && !sts.busy && !key_dirty && byte_offset == 4'd0 && !ks_fresh;

  // Deliver a pending byte once its key stream is ready and the output is free
  assign deliver = pend && !sts.busy && !sts.done && !key_dirty && !req.encrypt
                   && !(byte_offset == 4'd0 && !ks_fresh) && (!out_valid || out_ch.ready);

  assign key_wr = cfg_we && (cfg_index inside {actr_pkg::REG_KEY0, actr_pkg::REG_KEY1,
                                               actr_pkg::REG_KEY2, actr_pkg::REG_KEY3,
                                               actr_pkg::REG_KEYLEN});
  assign iv_wr = cfg_we && (cfg_index inside {actr_pkg::REG_IVHI, actr_pkg::REG_IVLO});

  assign ks_byte = ks_reg[127 - 8*byte_offset -: 8];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      key_length <= '0;
      iv_high <= '0;
      iv_low <= '0;
      key_dirty <= 1'b0;
    end else begin
      if (key_wr) key_dirty <= 1'b1;
      else if (req.expand) key_dirty <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          actr_pkg::REG_KEY0: key[255:192] <= cfg_data;
          actr_pkg::REG_KEY1: key[191:128] <= cfg_data;
          actr_pkg::REG_KEY2: key[127:64] <= cfg_data;
          actr_pkg::REG_KEY3: key[63:0] <= cfg_data;
          actr_pkg::REG_KEYLEN: key_length <= cfg_data[1:0];
          actr_pkg::REG_IVHI: iv_high <= cfg_data;
          actr_pkg::REG_IVLO: iv_low <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Counter, offset, pending byte and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_high <= '0;
      counter_low <= '0;
      byte_offset <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Refill the output register, or drop the item once taken
      if (deliver) begin
        out_valid <= 1'b1;
        out_data <= pend_data ^ ks_byte;
        out_last <= pend_last;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      // Hold a new item until its key stream is ready
      if (accept) begin
        pend <= 1'b1;
        pend_data <= in_ch.data;
        pend_last <= in_ch.last;
      end else if (deliver) begin
        pend <= 1'b0;
      end
      if (sts.done) ks_reg <= ks_blk;
      // Load the counter on an IV write; else advance the offset per byte, counter_low per block
      if (iv_wr) begin
        counter_high <= (cfg_index == actr_pkg::REG_IVHI) ? cfg_data : iv_high;
        counter_low <= (cfg_index == actr_pkg::REG_IVLO) ? cfg_data : iv_low;
        byte_offset <= '0;
      end else if (deliver) begin
        byte_offset <= byte_offset + 4'd1;
        if (byte_offset == 4'd15) counter_low <= counter_low + 64'd1;
      end
    end
  end

  // Mark that the key stream was just computed for the block at offset zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ks_fresh <= 1'b0;
    end else if (sts.done) begin
      ks_fresh <= 1'b1;
    end else if (deliver) begin
      ks_fresh <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;
  assign out_ch.last = out_last;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !pend && !sts.busy)
    else $error("item accepted while one is in flight");
  a_encrypt_at_zero: assert property (@(posedge clk) disable iff (rst)
    req.encrypt |-> byte_offset == 4'd0 && pend)
    else $error("encryption started mid-block");
  a_pend_then_out: assert property (@(posedge clk) disable iff (rst)
    $fell(pend) && !$past(cfg_we) |-> out_valid)
    else $error("pending item dropped");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the byte-serial AES counter-mode cipher.
// Depends on actr_pkg, actr_stream_if and aes_ctr_stream_cipher; predicts each byte
// with its own AES key expansion and block encryption and checks every output item.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  localparam logic [7:0] SUBST [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [actr_pkg::CfgIdxW-1:0] REG_NONE = 3'd7;
  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [actr_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [actr_pkg::CfgDataW-1:0] cfg_data = '0;

  actr_stream_if in_ch (clk);
  actr_stream_if out_ch (clk);

  aes_ctr_stream_cipher dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: registers, counter, offset, current key-stream block
  logic [63:0] key_w [4];
  logic [1:0]  key_len;
  logic [63:0] iv_hi, iv_lo, ctr_hi, ctr_lo;
  logic [3:0]  offs;
  logic [7:0]  stream_blk [16];
  logic [31:0] rkey [60];
  int          nrounds;

  byte_item_t pending_bytes [$];
  byte_item_t cipher_bytes [$];
  int errors = 0;
  int idle_mode = 0;

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic void expand_keys();
    logic [255:0] kall;
    logic [31:0] t;
    logic [7:0] rc;
    int nk;
    kall = {key_w[0], key_w[1], key_w[2], key_w[3]};
    nk = (key_len == actr_pkg::KEYLEN_128) ? 4 : (key_len == actr_pkg::KEYLEN_192) ? 6 : 8;
    nrounds = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < 60; i++) rkey[i] = '0;
    for (int i = 0; i < nk; i++) rkey[i] = kall[255-32*i -: 32];
    for (int i = nk; i < 4 * (nrounds + 1); i++) begin
      t = rkey[i-1];
      if (i % nk == 0) begin
        t = {SUBST[t[23:16]] ^ rc, SUBST[t[15:8]], SUBST[t[7:0]], SUBST[t[31:24]]};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = {SUBST[t[31:24]], SUBST[t[23:16]], SUBST[t[15:8]], SUBST[t[7:0]]};
      end
      rkey[i] = rkey[i-nk] ^ t;
    end
  endfunction

  function automatic logic [7:0] rk_byte(input int r, input int i);
    logic [31:0] w;
    w = rkey[4*r + i/4];
    return w[31-8*(i%4) -: 8];
  endfunction

  // Encrypt the current counter block into the key-stream store
  function automatic void encrypt_counter();
    logic [127:0] blk;
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    blk = {ctr_hi, ctr_lo};
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk_byte(0, i);
    for (int r = 1; r <= nrounds; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = SUBST[s[i + 4*((c+i) & 3)]];
      if (r != nrounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk_byte(r, i);
    end
    for (int i = 0; i < 16; i++) stream_blk[i] = s[i];
  endfunction

  function automatic byte_item_t cipher_byte(input byte_item_t it);
    byte_item_t o;
    if (offs == 4'd0) encrypt_counter();
    o.data = it.data ^ stream_blk[offs];
    o.last = it.last;
    offs = offs + 4'd1;
    if (offs == 4'd0) ctr_lo = ctr_lo + 64'd1;
    return o;
  endfunction

  function automatic void update_regs(input logic [actr_pkg::CfgIdxW-1:0] idx,
                                      input logic [63:0] v);
    case (idx)
      actr_pkg::REG_KEY0, actr_pkg::REG_KEY1, actr_pkg::REG_KEY2, actr_pkg::REG_KEY3: begin
        key_w[idx[1:0]] = v;
        expand_keys();
      end
      actr_pkg::REG_KEYLEN: begin
        key_len = v[1:0];
        expand_keys();
      end
      actr_pkg::REG_IVHI, actr_pkg::REG_IVLO: begin
        if (idx == actr_pkg::REG_IVHI) iv_hi = v;
        else iv_lo = v;
        ctr_hi = iv_hi;
        ctr_lo = iv_lo;
        offs = 4'd0;
      end
      default: ;
    endcase
  endfunction

  // Driver: present the next pending item, hold it until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      in_ch.last <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_bytes.size() > 0 &&
          !(idle_mode == 0 ? $urandom_range(99) < 6 :
            idle_mode == 1 ? $urandom_range(99) < 55 : 1'b0)) begin
        byte_item_t it;
        it = pending_bytes.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data <= it.data;
        in_ch.last <= it.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= idle_mode == 0 ? $urandom_range(99) >= 55 :
                         idle_mode == 1 ? $urandom_range(99) >= 6 : 1'b1;
  end

  // Monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        byte_item_t it;
        it.data = in_ch.data;
        it.last = in_ch.last;
        cipher_bytes.push_back(cipher_byte(it));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (cipher_bytes.size() == 0) begin
          $error("unexpected output item data_out=%0h", out_ch.data);
          errors++;
        end else begin
          byte_item_t exp_b;
          exp_b = cipher_bytes.pop_front();
          if (out_ch.data !== exp_b.data) begin
            $error("data_out expected %0h actual %0h", exp_b.data, out_ch.data);
            errors++;
          end
          if (out_ch.last !== exp_b.last) begin
            $error("last_out expected %0h actual %0h", exp_b.last, out_ch.last);
            errors++;
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_bytes.size() > 0 || in_ch.valid || cipher_bytes.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Write one register, then let the key expansion settle
  task automatic write_reg(input logic [actr_pkg::CfgIdxW-1:0] idx, input logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    update_regs(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (80) @(posedge clk);
  endtask

  task automatic queue_bytes(input int n);
    byte_item_t it;
    for (int i = 0; i < n; i++) begin
      it.data = 8'($urandom);
      it.last = ($urandom_range(15) == 0);
      pending_bytes.push_back(it);
    end
  endtask

  initial begin
    byte_item_t it;
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    key_len = 2'd0;
    iv_hi = '0; iv_lo = '0; ctr_hi = '0; ctr_lo = '0;
    offs = 4'd0;
    for (int i = 0; i < 16; i++) stream_blk[i] = '0;
    expand_keys();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (80) @(posedge clk);

    // Directed: all-zero key, extreme bytes, a chunk end inside a block
    for (int i = 0; i < 20; i++) begin
      it.data = (i % 2) ? 8'hFF : 8'h00;
      it.last = (i == 5 || i == 19);
      pending_bytes.push_back(it);
    end
    wait_idle();
    // All-ones 128-bit key, counter about to wrap across a block boundary
    write_reg(actr_pkg::REG_KEY0, ONES);
    write_reg(actr_pkg::REG_KEY1, ONES);
    write_reg(actr_pkg::REG_IVHI, ONES);
    write_reg(actr_pkg::REG_IVLO, ONES);
    queue_bytes(24);
    wait_idle();
    // Key change mid-block, unknown index, then the largest key length
    write_reg(actr_pkg::REG_KEY2, ONES);
    write_reg(actr_pkg::REG_KEY3, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_NONE, ONES);
    write_reg(actr_pkg::REG_KEYLEN, 64'd3);
    queue_bytes(12);
    wait_idle();

    // Random phases with fresh settings
    for (int p = 0; p < 12; p++) begin
      idle_mode = p / 4;
      for (int r = 0; r < 4; r++)
        if ($urandom_range(1)) write_reg(r[actr_pkg::CfgIdxW-1:0], {$urandom, $urandom});
      write_reg(actr_pkg::REG_KEYLEN, 64'(p % 4));
      if ($urandom_range(3) != 0) write_reg(actr_pkg::REG_IVHI, {$urandom, $urandom});
      if ($urandom_range(3) == 0)
        write_reg(actr_pkg::REG_IVLO, ONES - 64'($urandom_range(2)));
      else if ($urandom_range(1)) write_reg(actr_pkg::REG_IVLO, {$urandom, $urandom});
      queue_bytes(95);
      wait_idle();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: aes_ctr_stream_cipher.f
sv/actr_pkg.sv
sv/actr_stream_if.sv
sv/actr_core.sv
sv/aes_ctr_stream_cipher.sv
tb/tb_top.sv
